// ===== rtl/mvia_pkg.sv =====
// Package for the masked vector integer ALU: lane count, operation codes and
// the word types passed between the front end, the queue and the back end.
// No dependencies.
`default_nettype none
package mvia_pkg;
   localparam int LANES = 4;
   localparam int QDEPTH = 4;
   localparam int QIDX_W = $clog2(QDEPTH);

   localparam logic [4:0] MODE_ONES = 5'd0;
   localparam logic [4:0] MODE_NOT = 5'd1;
   localparam logic [4:0] MODE_OR = 5'd2;
   localparam logic [4:0] MODE_AND = 5'd3;
   localparam logic [4:0] MODE_COUNT = 5'd4;
   localparam logic [4:0] MODE_SET = 5'd5;
   localparam logic [4:0] MODE_MOVE = 5'd6;
   localparam logic [4:0] MODE_ADD = 5'd7;
   localparam logic [4:0] MODE_SUB = 5'd8;
   localparam logic [4:0] MODE_MUL = 5'd9;
   localparam logic [4:0] MODE_DIV = 5'd10;
   localparam logic [4:0] MODE_ABS = 5'd11;
   localparam logic [4:0] MODE_GT = 5'd12;
   localparam logic [4:0] MODE_LT = 5'd13;
   localparam logic [4:0] MODE_EQ = 5'd14;
   localparam logic [4:0] MODE_HADD = 5'd15;
   localparam logic [4:0] MODE_ILV = 5'd16;

   typedef enum logic [3:0] {
      OP_NONE, OP_SET, OP_MOVE, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
      OP_ABS, OP_GT, OP_LT, OP_EQ, OP_HADD, OP_ILV
   } op_type;

   typedef struct packed {
      op_type                   op;
      logic [LANES-1:0]         mask;
      logic [LANES-1:0]         mask_out;
      logic [LANES-1:0]         written;
      logic [2:0]               count;
      logic [LANES-1:0][31:0]   a;
      logic [LANES-1:0][31:0]   b;
      logic [31:0]              scalar;
   } item_type;

   typedef struct packed {
      logic [LANES-1:0][31:0]   r;
      logic [LANES-1:0]         mask_out;
      logic [LANES-1:0]         written;
      logic [2:0]               count;
      logic [LANES-1:0]         fault;
   } result_type;
endpackage
`default_nettype wire

// ===== rtl/mvia_front.sv =====
// Front end: decodes the mode, passes the lane mask on and finishes the mask
// operations. Depends on mvia_pkg.
`default_nettype none
module mvia_front import mvia_pkg::*; (
   input  wire logic [4:0]             mode,
   input  wire logic [3:0]             lane_mask,
   input  wire logic [3:0]             other_mask,
   input  wire logic [LANES-1:0][31:0] a,
   input  wire logic [LANES-1:0][31:0] b,
   input  wire logic [31:0]            scalar,
   output item_type                    item
);
   logic [LANES-1:0] m;
   logic [LANES-1:0] om;

   always_comb begin
      m = lane_mask[LANES-1:0];
      om = other_mask[LANES-1:0];
      item = '0;
      item.mask = m;
      item.a = a;
      item.b = b;
      item.scalar = scalar;
      unique case (mode)
         MODE_ONES: begin
            for (int i = 0; i < LANES; i++) begin
               item.mask_out[i] = $signed(scalar) > $signed(32'(i));
            end
            item.written = '1;
         end
         MODE_NOT: begin
            item.mask_out = ~m;
            item.written = '1;
         end
         MODE_OR: begin
            item.mask_out = m | om;
            item.written = '1;
         end
         MODE_AND: begin
            item.mask_out = m & om;
            item.written = '1;
         end
         MODE_COUNT: begin
            for (int i = 0; i < LANES; i++) begin
               item.count = item.count + 3'(m[i]);
            end
         end
         MODE_SET: item.op = OP_SET;
         MODE_MOVE: item.op = OP_MOVE;
         MODE_ADD: item.op = OP_ADD;
         MODE_SUB: item.op = OP_SUB;
         MODE_MUL: item.op = OP_MUL;
         MODE_DIV: item.op = OP_DIV;
         MODE_ABS: item.op = OP_ABS;
         MODE_GT: item.op = OP_GT;
         MODE_LT: item.op = OP_LT;
         MODE_EQ: item.op = OP_EQ;
         MODE_HADD: item.op = OP_HADD;
         MODE_ILV: item.op = OP_ILV;
         default: item.op = OP_NONE;
      endcase
   end
endmodule
`default_nettype wire

// ===== rtl/mvia_queue.sv =====
// Short queue of decoded words between the front end and the back end.
// Depends on mvia_pkg.
`default_nettype none
module mvia_queue import mvia_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  item_type      push_item,
   input  wire logic     pop,
   output logic          full,
   output logic          not_empty,
   output item_type      head,
   output logic [QIDX_W:0] fill
);
   item_type              mem_ff [QDEPTH];
   logic [QIDX_W-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [QIDX_W:0]       cnt_ff, cnt_in;

   assign full = cnt_ff == (QIDX_W+1)'(QDEPTH);
   assign not_empty = cnt_ff != '0;
   assign head = mem_ff[rd_ff];
   assign fill = cnt_ff;

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QIDX_W+1)'(push) - (QIDX_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/mvia_back.sv =====
// Back end: carries out lane and cross-lane operations, runs a shared
// four-lane restoring divider and holds the output word. Depends on mvia_pkg.
`default_nettype none
module mvia_back import mvia_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     have_item,
   input  item_type      head,
   output logic          pop,
   output logic          out_valid,
   input  wire logic     out_stall,
   output result_type    out_word
);
   typedef enum logic {ST_RUN, ST_DIV} state_type;

   state_type               state_ff, state_in;
   logic                    valid_ff, valid_in;
   result_type              res_ff, res_in;
   logic [5:0]              steps_ff, steps_in;
   logic [LANES-1:0][31:0]  rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic [LANES-1:0]        neg_ff, neg_in;
   logic                    out_free;
   result_type              lane_res, div_res;
   logic [32:0]             trial;
   logic [31:0]             sa, sb;

   assign out_free = !valid_ff || !out_stall;
   assign out_valid = valid_ff;
   assign out_word = res_ff;

   always_comb begin
      lane_res = '0;
      lane_res.mask_out = head.mask_out;
      lane_res.written = head.written;
      lane_res.count = head.count;
      if (head.op != OP_NONE && head.op != OP_HADD && head.op != OP_ILV) begin
         lane_res.written = head.mask;
      end
      for (int i = 0; i < LANES; i++) begin
         sa = head.a[i];
         sb = head.b[i];
         case (head.op)
            OP_SET: lane_res.r[i] = head.scalar;
            OP_MOVE: lane_res.r[i] = sa;
            OP_ADD: lane_res.r[i] = sa + sb;
            OP_SUB: lane_res.r[i] = sa - sb;
            OP_MUL: lane_res.r[i] = sa * sb;
            OP_ABS: lane_res.r[i] = sa[31] ? 32'(-sa) : sa;
            OP_GT: lane_res.mask_out[i] = $signed(sa) > $signed(sb);
            OP_LT: lane_res.mask_out[i] = $signed(sa) < $signed(sb);
            OP_EQ: lane_res.mask_out[i] = sa == sb;
            default: lane_res.r[i] = '0;
         endcase
         if (!head.mask[i] && head.op != OP_NONE) begin
            lane_res.r[i] = '0;
            lane_res.mask_out[i] = 1'b0;
         end
      end
      if (head.op == OP_HADD) begin
         lane_res.written = '0;
         for (int i = 0; i + 1 < LANES; i += 2) begin
            lane_res.r[i] = head.a[i] + head.a[i+1];
            lane_res.r[i+1] = head.a[i] + head.a[i+1];
            lane_res.written[i] = 1'b1;
            lane_res.written[i+1] = 1'b1;
         end
      end
      if (head.op == OP_ILV) begin
         lane_res.written = '0;
         for (int i = 0; i < LANES; i++) begin
            if (i < LANES / 2) begin
               lane_res.r[i] = head.a[2*i];
               lane_res.written[i] = 1'b1;
            end else if (2 * (i - LANES / 2) + 1 < LANES) begin
               lane_res.r[i] = head.a[2*(i-LANES/2)+1];
               lane_res.written[i] = 1'b1;
            end
         end
      end

      div_res = '0;
      div_res.written = head.mask;
      for (int i = 0; i < LANES; i++) begin
         if (head.mask[i]) begin
            if (head.b[i] == '0) begin
               div_res.fault[i] = 1'b1;
            end else begin
               div_res.r[i] = neg_ff[i] ? 32'(-quo_ff[i]) : quo_ff[i];
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff && out_stall;
      res_in = res_ff;
      steps_in = steps_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      pop = 1'b0;
      trial = '0;
      unique case (state_ff)
         ST_RUN: begin
            if (have_item && head.op == OP_DIV) begin
               state_in = ST_DIV;
               steps_in = 6'd32;
               for (int i = 0; i < LANES; i++) begin
                  rem_in[i] = '0;
                  quo_in[i] = head.a[i][31] ? 32'(-head.a[i]) : head.a[i];
                  den_in[i] = head.b[i][31] ? 32'(-head.b[i]) : head.b[i];
                  neg_in[i] = head.a[i][31] ^ head.b[i][31];
               end
            end else if (have_item && out_free) begin
               pop = 1'b1;
               valid_in = 1'b1;
               res_in = lane_res;
            end
         end
         ST_DIV: begin
            if (steps_ff != '0) begin
               steps_in = steps_ff - 1'b1;
               for (int i = 0; i < LANES; i++) begin
                  trial = {rem_ff[i], quo_ff[i][31]};
                  if (trial >= {1'b0, den_ff[i]}) begin
                     trial = trial - {1'b0, den_ff[i]};
                     quo_in[i] = {quo_ff[i][30:0], 1'b1};
                  end else begin
                     quo_in[i] = {quo_ff[i][30:0], 1'b0};
                  end
                  rem_in[i] = trial[31:0];
               end
            end else if (out_free) begin
               pop = 1'b1;
               valid_in = 1'b1;
               res_in = div_res;
               state_in = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         valid_ff <= 1'b0;
         steps_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         steps_ff <= steps_in;
      end
      res_ff <= res_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end
endmodule
`default_nettype wire

// ===== rtl/masked_vector_integer_alu_unit.sv =====
// Four-lane masked integer vector ALU, top level.
// Depends on mvia_pkg, mvia_front, mvia_queue and mvia_back.
//
// A request word carries a mode, a lane mask, a second mask, two operand
// vectors and a scalar; each request gives exactly one response word with
// four result lanes, a mask, the lanes written, a bit count and divide faults.
// Both channels use valid and stall; a word moves on an edge where valid is
// high and stall is low.
// The front end decodes the request and writes it into a four-word queue in
// the same cycle. The back end takes one word per cycle from the queue head
// into the output register while the output is free and no divide runs, so
// non-divide words pass through a queue entry and the output register and
// can follow each other every cycle. A divide word at the queue head runs a
// shared restoring divider one quotient bit per cycle on all lanes at once,
// then moves to the output once it is free. While it runs the queue can fill
// and req_stall rises once it is full. When rsp_stall is high the output word
// holds; the queue still accepts up to four requests behind it.
// Reset empties the queue and clears the output valid.
`default_nettype none
module masked_vector_integer_alu_unit import mvia_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [4:0]  req_mode,
   input  wire logic [3:0]  req_lane_mask,
   input  wire logic [3:0]  req_other_mask,
   input  wire logic [31:0] req_a_lane0,
   input  wire logic [31:0] req_a_lane1,
   input  wire logic [31:0] req_a_lane2,
   input  wire logic [31:0] req_a_lane3,
   input  wire logic [31:0] req_b_lane0,
   input  wire logic [31:0] req_b_lane1,
   input  wire logic [31:0] req_b_lane2,
   input  wire logic [31:0] req_b_lane3,
   input  wire logic [31:0] req_scalar,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_r_lane0,
   output logic [31:0]      rsp_r_lane1,
   output logic [31:0]      rsp_r_lane2,
   output logic [31:0]      rsp_r_lane3,
   output logic [3:0]       rsp_mask_out,
   output logic [3:0]       rsp_lanes_written,
   output logic [2:0]       rsp_bit_count,
   output logic [3:0]       rsp_div_fault
);
   item_type               dec_item, head;
   logic                   q_full, q_ne, pop, push;
   logic [QIDX_W:0]        q_fill;
   result_type             res;

   assign push = req_valid && !q_full;
   assign req_stall = q_full;

   mvia_front u_front (
      .mode(req_mode), .lane_mask(req_lane_mask), .other_mask(req_other_mask),
      .a({req_a_lane3, req_a_lane2, req_a_lane1, req_a_lane0}),
      .b({req_b_lane3, req_b_lane2, req_b_lane1, req_b_lane0}),
      .scalar(req_scalar), .item(dec_item)
   );

   mvia_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_item(dec_item),
      .pop(pop), .full(q_full), .not_empty(q_ne), .head(head), .fill(q_fill)
   );

   mvia_back u_back (
      .clock(clock), .reset(reset), .have_item(q_ne), .head(head), .pop(pop),
      .out_valid(rsp_valid), .out_stall(rsp_stall), .out_word(res)
   );

   assign rsp_r_lane0 = res.r[0];
   assign rsp_r_lane1 = res.r[1];
   assign rsp_r_lane2 = res.r[2];
   assign rsp_r_lane3 = res.r[3];
   assign rsp_mask_out = res.mask_out;
   assign rsp_lanes_written = res.written;
   assign rsp_bit_count = res.count;
   assign rsp_div_fault = res.fault;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      q_fill <= (QIDX_W+1)'(QDEPTH)) else $error("queue overfilled");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_ne) else $error("pop from empty queue");
   a_fault_written: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_div_fault & ~rsp_lanes_written) == 4'd0)
      else $error("fault on unwritten lane");
   a_count_nowrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bit_count != 3'd0) |-> rsp_lanes_written == 4'd0)
      else $error("count wrote lanes");
endmodule
`default_nettype wire

// ===== test/mvia_checker.sv =====
// Checker for the masked vector integer ALU: watches both channels, predicts
// each response word from the request word and compares them field by field.
// Depends on mvia_pkg.
`timescale 1ns / 1ps
module mvia_checker import mvia_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [4:0]  req_mode,
   input  wire logic [3:0]  req_lane_mask,
   input  wire logic [3:0]  req_other_mask,
   input  wire logic [31:0] req_a_lane0,
   input  wire logic [31:0] req_a_lane1,
   input  wire logic [31:0] req_a_lane2,
   input  wire logic [31:0] req_a_lane3,
   input  wire logic [31:0] req_b_lane0,
   input  wire logic [31:0] req_b_lane1,
   input  wire logic [31:0] req_b_lane2,
   input  wire logic [31:0] req_b_lane3,
   input  wire logic [31:0] req_scalar,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [31:0] rsp_r_lane0,
   input  wire logic [31:0] rsp_r_lane1,
   input  wire logic [31:0] rsp_r_lane2,
   input  wire logic [31:0] rsp_r_lane3,
   input  wire logic [3:0]  rsp_mask_out,
   input  wire logic [3:0]  rsp_lanes_written,
   input  wire logic [2:0]  rsp_bit_count,
   input  wire logic [3:0]  rsp_div_fault,
   output int               fail_count,
   output int               pending_count,
   output int               words_checked
);
   result_type expected_words[$];

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
      fail_count++;
   endtask

   function automatic result_type compute_word(
         input logic [4:0] mode, input logic [3:0] m, input logic [3:0] om,
         input logic [3:0][31:0] a, input logic [3:0][31:0] b,
         input logic [31:0] sc);
      result_type w;
      logic signed [31:0] x;
      logic signed [31:0] y;
      w = '0;
      case (mode)
         MODE_ONES: begin
            for (int i = 0; i < 4; i++) w.mask_out[i] = $signed(sc) > i;
            w.written = 4'hF;
         end
         MODE_NOT: begin w.mask_out = ~m; w.written = 4'hF; end
         MODE_OR: begin w.mask_out = m | om; w.written = 4'hF; end
         MODE_AND: begin w.mask_out = m & om; w.written = 4'hF; end
         MODE_COUNT: w.count = m[0] + m[1] + m[2] + m[3];
         MODE_HADD: begin
            w.r[0] = a[0] + a[1]; w.r[1] = w.r[0];
            w.r[2] = a[2] + a[3]; w.r[3] = w.r[2];
            w.written = 4'hF;
         end
         MODE_ILV: begin
            w.r[0] = a[0]; w.r[1] = a[2]; w.r[2] = a[1]; w.r[3] = a[3];
            w.written = 4'hF;
         end
         default: begin
            if (mode >= MODE_SET && mode <= MODE_EQ) begin
               w.written = m;
               for (int i = 0; i < 4; i++) begin
                  x = a[i];
                  y = b[i];
                  if (m[i]) begin
                     case (mode)
                        MODE_SET: w.r[i] = sc;
                        MODE_MOVE: w.r[i] = x;
                        MODE_ADD: w.r[i] = x + y;
                        MODE_SUB: w.r[i] = x - y;
                        MODE_MUL: w.r[i] = x * y;
                        MODE_DIV: begin
                           if (y == 0) w.fault[i] = 1'b1;
                           else if (x == 32'sh80000000 && y == -1) w.r[i] = x;
                           else w.r[i] = x / y;
                        end
                        MODE_ABS: w.r[i] = x < 0 ? -x : x;
                        MODE_GT: w.mask_out[i] = x > y;
                        MODE_LT: w.mask_out[i] = x < y;
                        default: w.mask_out[i] = x == y;
                     endcase
                  end
               end
            end
         end
      endcase
      return w;
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         fail_count <= 0;
         words_checked <= 0;
         expected_words.delete();
      end else begin
         if (req_valid && !req_stall)
            expected_words.push_back(compute_word(req_mode, req_lane_mask,
               req_other_mask, {req_a_lane3, req_a_lane2, req_a_lane1, req_a_lane0},
               {req_b_lane3, req_b_lane2, req_b_lane1, req_b_lane0}, req_scalar));
         if (rsp_valid && !rsp_stall) begin
            words_checked <= words_checked + 1;
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected word, r_lane0", rsp_r_lane0, '0);
            end else begin
               want = expected_words.pop_front();
               if (rsp_r_lane0 !== want.r[0]) report_mismatch("r_lane0", rsp_r_lane0, want.r[0]);
               if (rsp_r_lane1 !== want.r[1]) report_mismatch("r_lane1", rsp_r_lane1, want.r[1]);
               if (rsp_r_lane2 !== want.r[2]) report_mismatch("r_lane2", rsp_r_lane2, want.r[2]);
               if (rsp_r_lane3 !== want.r[3]) report_mismatch("r_lane3", rsp_r_lane3, want.r[3]);
               if (rsp_mask_out !== want.mask_out)
                  report_mismatch("mask_out", rsp_mask_out, want.mask_out);
               if (rsp_lanes_written !== want.written)
                  report_mismatch("lanes_written", rsp_lanes_written, want.written);
               if (rsp_bit_count !== want.count)
                  report_mismatch("bit_count", rsp_bit_count, want.count);
               if (rsp_div_fault !== want.fault)
                  report_mismatch("div_fault", rsp_div_fault, want.fault);
            end
         end
      end
      pending_count = expected_words.size();
   end
endmodule

// ===== test/tb_masked_vector_integer_alu_unit.sv =====
// Testbench top for the masked vector integer ALU: drives directed and random
// request words with random idling and stalls; mvia_checker does the checking.
// Depends on mvia_pkg, mvia_checker and the block's RTL.
`timescale 1ns / 1ps
module tb_masked_vector_integer_alu_unit;
   import mvia_pkg::*;

   localparam int IDLE_LIMIT = 5000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [4:0]  req_mode;
   logic [3:0]  req_lane_mask;
   logic [3:0]  req_other_mask;
   logic [31:0] req_a_lane0, req_a_lane1, req_a_lane2, req_a_lane3;
   logic [31:0] req_b_lane0, req_b_lane1, req_b_lane2, req_b_lane3;
   logic [31:0] req_scalar;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_r_lane0, rsp_r_lane1, rsp_r_lane2, rsp_r_lane3;
   logic [3:0]  rsp_mask_out;
   logic [3:0]  rsp_lanes_written;
   logic [2:0]  rsp_bit_count;
   logic [3:0]  rsp_div_fault;
   int          fail_count;
   int          pending_count;
   int          words_checked;
   int          words_sent;
   int          idle_cycles;
   bit          quiet_stretch;
   bit          long_hold;

   masked_vector_integer_alu_unit dut (.*);
   mvia_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h80000000;
         1: return 32'h7FFFFFFF;
         2: return 32'hFFFFFFFF;
         3: return 32'd0;
         4: return $urandom_range(0, 9);
         5: return -$urandom_range(0, 9);
         default: return $urandom;
      endcase
   endfunction

   // The word stays offered after acceptance until the next call or drop_valid
   // replaces it in the same time step.
   task automatic send_word(input logic [4:0] mode, input logic [3:0] m,
                            input logic [3:0] om, input logic [3:0][31:0] a,
                            input logic [3:0][31:0] b, input logic [31:0] sc);
      while (!quiet_stretch && $urandom_range(0, 99) < 20) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_lane_mask <= m;
      req_other_mask <= om;
      {req_a_lane3, req_a_lane2, req_a_lane1, req_a_lane0} <= a;
      {req_b_lane3, req_b_lane2, req_b_lane1, req_b_lane0} <= b;
      req_scalar <= sc;
      do @(posedge clock); while (req_stall);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
   endtask

   task automatic send_random();
      logic [3:0][31:0] a;
      logic [3:0][31:0] b;
      logic [4:0] mode;
      for (int i = 0; i < 4; i++) begin
         a[i] = pick_value();
         b[i] = ($urandom_range(0, 3) == 0) ? a[i] : pick_value();
      end
      mode = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(17, 31))
                                           : 5'($urandom_range(0, 16));
      if (mode == MODE_DIV && $urandom_range(0, 1)) mode = MODE_ADD;
      send_word(mode, 4'($urandom), 4'($urandom), a, b,
                ($urandom_range(0, 1)) ? 32'($signed($urandom_range(0, 10)) - 3)
                                       : pick_value());
   endtask

   always @(negedge clock) begin
      if (reset || quiet_stretch) rsp_stall <= 1'b0;
      else if (long_hold) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(0, 99) < 20);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      logic [3:0][31:0] a;
      logic [3:0][31:0] b;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = '0;
      req_lane_mask = '0;
      req_other_mask = '0;
      {req_a_lane3, req_a_lane2, req_a_lane1, req_a_lane0} = '0;
      {req_b_lane3, req_b_lane2, req_b_lane1, req_b_lane0} = '0;
      req_scalar = '0;
      rsp_stall = 1'b0;
      words_sent = 0;
      quiet_stretch = 1'b0;
      long_hold = 1'b0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      a = {32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'd7};
      b = {32'd1, 32'hFFFFFFFF, 32'd0, 32'hFFFFFFFE};
      for (int mode = 0; mode <= 16; mode++)
         send_word(5'(mode), 4'hF, 4'h5, a, b, 32'd2);
      send_word(MODE_ONES, 4'h0, 4'h0, a, b, 32'h80000000);
      send_word(MODE_ONES, 4'h0, 4'h0, a, b, 32'h7FFFFFFF);
      send_word(MODE_ONES, 4'h0, 4'h0, a, b, 32'd0);
      send_word(MODE_DIV, 4'hA, 4'h0, a, b, 32'd0);
      send_word(MODE_SET, 4'h0, 4'hF, a, b, 32'h80000000);
      send_word(MODE_ABS, 4'h6, 4'h0, b, a, 32'd0);
      send_word(5'd31, 4'hF, 4'hF, a, b, 32'hFFFFFFFF);
      send_word(5'd17, 4'hF, 4'hF, a, b, 32'hFFFFFFFF);

      quiet_stretch = 1'b1;
      repeat (150) send_random();
      quiet_stretch = 1'b0;

      fork
         begin
            long_hold = 1'b1;
            repeat (200) @(negedge clock);
            long_hold = 1'b0;
         end
         begin
            repeat (20) send_random();
            drop_valid();
         end
      join

      wait (pending_count == 0);
      repeat (400) send_random();
      drop_valid();
      wait (pending_count == 0);
      repeat (230) send_random();
      drop_valid();

      wait (pending_count == 0);
      repeat (50) @(posedge clock);
      $display("sent %0d request words, checked %0d response words", words_sent,
               words_checked);
      $display("covered all modes, unknown modes, divide faults and long stalls");
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

// ===== files.f =====
rtl/mvia_pkg.sv
rtl/mvia_front.sv
rtl/mvia_queue.sv
rtl/mvia_back.sv
rtl/masked_vector_integer_alu_unit.sv
test/mvia_checker.sv
test/tb_masked_vector_integer_alu_unit.sv
